// ----- rtl/core/bcd_pkg.sv -----
package bcd_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned ACC_W     = 48;
	localparam int unsigned POS_W     = 32;
	localparam int unsigned INV_W     = 24;
	localparam int unsigned CNT_W     = 7;
	localparam int unsigned COL_W     = 6;
	localparam int unsigned ROW_W     = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned WGT_W     = FRAC_BITS + 1;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_SCALE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE  = 3'd6;

	localparam logic OP_DEPOSIT = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOCATE,
		ST_CHECK,
		ST_WEIGHT,
		ST_AMOUNT,
		ST_RD,
		ST_ADD,
		ST_WR,
		ST_READ_WAIT,
		ST_READ_DATA,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       clear_step;
		logic       capture;
		logic       locate;
		logic       check;
		logic       weight;
		logic       amount;
		logic       mem_rd;
		logic       add;
		logic       mem_wr;
		logic       cell_rd;
		logic       cell_latch;
		logic       next_corner;
	} dp_cmd_t;

	typedef struct packed {
		logic       clear_done;
		logic       is_read;
		logic       skip;
		logic       last_corner;
	} dp_sts_t;

endpackage

// ----- rtl/core/bilinear_charge_deposit_unit.sv -----
// Sequence: a read passes LOCATE, READ_WAIT and READ_DATA before OUT; a deposit
// passes LOCATE, CHECK, then per corner WEIGHT, AMOUNT, RD, ADD and WR, making
// four read-modify-write passes through the single-port accumulator store, or
// goes from AMOUNT straight to OUT when outside the grid. One transaction at a
// time: the next is taken in IDLE after the result is accepted.
// Reset: asynchronous active low; registers to reset values, then a clearing
// pass of (MAX_ROWS+1)*MAX_COLS writes before in_ready rises.
module bilinear_charge_deposit_unit #(
	parameter int unsigned MAX_COLS = 64,
	parameter int unsigned MAX_ROWS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  operation,
	input  logic signed [bcd_pkg::POS_W-1:0]      pos_x,
	input  logic signed [bcd_pkg::POS_W-1:0]      pos_y,
	input  logic                                  lane_active,
	input  logic [bcd_pkg::COL_W-1:0]             read_col,
	input  logic [bcd_pkg::ROW_W-1:0]             read_row,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [bcd_pkg::ACC_W-1:0]      cell_value,
	output logic [bcd_pkg::COL_W-1:0]             col_index,
	output logic [bcd_pkg::ROW_W-1:0]             row_index,
	output logic                                  out_of_range,
	input  logic                                  cfg_we,
	input  logic [bcd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bcd_pkg::POS_W-1:0]             cfg_data
);
	logic signed [bcd_pkg::POS_W-1:0] origin_x_q, origin_y_q, charge_scale_q;
	logic [bcd_pkg::INV_W-1:0]        inv_cell_x_q, inv_cell_y_q;
	logic [bcd_pkg::CNT_W-1:0]        cols_q, rows_q;
	bcd_pkg::dp_cmd_t cmd;
	bcd_pkg::dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			inv_cell_x_q   <= bcd_pkg::INV_W'(65536);
			inv_cell_y_q   <= bcd_pkg::INV_W'(65536);
			charge_scale_q <= '0;
			cols_q         <= bcd_pkg::CNT_W'(64);
			rows_q         <= bcd_pkg::CNT_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				bcd_pkg::REG_ORIGIN_X:     origin_x_q     <= cfg_data;
				bcd_pkg::REG_ORIGIN_Y:     origin_y_q     <= cfg_data;
				bcd_pkg::REG_INV_CELL_X:   inv_cell_x_q   <= cfg_data[bcd_pkg::INV_W-1:0];
				bcd_pkg::REG_INV_CELL_Y:   inv_cell_y_q   <= cfg_data[bcd_pkg::INV_W-1:0];
				bcd_pkg::REG_CHARGE_SCALE: charge_scale_q <= cfg_data;
				bcd_pkg::REG_COLS_IN_USE:  cols_q         <= cfg_data[bcd_pkg::CNT_W-1:0];
				bcd_pkg::REG_ROWS_IN_USE:  rows_q         <= cfg_data[bcd_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	bcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	bcd_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_operation(operation), .in_pos_x(pos_x), .in_pos_y(pos_y),
		.in_lane_active(lane_active), .in_read_col(read_col),
		.in_read_row(read_row), .origin_x(origin_x_q), .origin_y(origin_y_q),
		.inv_cell_x(inv_cell_x_q), .inv_cell_y(inv_cell_y_q),
		.charge_scale(charge_scale_q), .cols_in_use(cols_q),
		.rows_in_use(rows_q), .res_cell_value(cell_value),
		.res_col_index(col_index), .res_row_index(row_index),
		.res_out_of_range(out_of_range)
	);

	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready during pending result");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid) else $error("result repeated");
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sts.is_read |-> !out_of_range) else $error("read flagged");
endmodule

// ----- rtl/core/bcd_datapath.sv -----
module bcd_datapath #(
	parameter int unsigned MAX_COLS = 64,
	parameter int unsigned MAX_ROWS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bcd_pkg::dp_cmd_t                  cmd,
	output bcd_pkg::dp_sts_t                  sts,
	input  logic                              in_operation,
	input  logic signed [bcd_pkg::POS_W-1:0]  in_pos_x,
	input  logic signed [bcd_pkg::POS_W-1:0]  in_pos_y,
	input  logic                              in_lane_active,
	input  logic [bcd_pkg::COL_W-1:0]         in_read_col,
	input  logic [bcd_pkg::ROW_W-1:0]         in_read_row,
	input  logic signed [bcd_pkg::POS_W-1:0]  origin_x,
	input  logic signed [bcd_pkg::POS_W-1:0]  origin_y,
	input  logic [bcd_pkg::INV_W-1:0]         inv_cell_x,
	input  logic [bcd_pkg::INV_W-1:0]         inv_cell_y,
	input  logic signed [bcd_pkg::POS_W-1:0]  charge_scale,
	input  logic [bcd_pkg::CNT_W-1:0]         cols_in_use,
	input  logic [bcd_pkg::CNT_W-1:0]         rows_in_use,
	output logic signed [bcd_pkg::ACC_W-1:0]  res_cell_value,
	output logic [bcd_pkg::COL_W-1:0]         res_col_index,
	output logic [bcd_pkg::ROW_W-1:0]         res_row_index,
	output logic                              res_out_of_range
);
	localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
	localparam int unsigned DEPTH = (MAX_ROWS + 1) * MAX_COLS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned FB    = bcd_pkg::FRAC_BITS;
	localparam int unsigned WW    = bcd_pkg::WGT_W;
	localparam int unsigned PW    = 58;
	localparam int unsigned BW    = PW - 32;
	localparam logic [WW-1:0] ONE = WW'(1) << FB;

	logic [bcd_pkg::ACC_W-1:0] mem [DEPTH];

	logic                        op_q, lane_q;
	logic signed [bcd_pkg::POS_W-1:0] px_q, py_q;
	logic [bcd_pkg::COL_W-1:0]   rcol_q;
	logic [bcd_pkg::ROW_W-1:0]   rrow_q;
	logic signed [PW-1:0]        prx_q, pry_q;
	logic [CW-1:0]               c0_q, c1_q;
	logic [RW-1:0]               r0_q;
	logic [WW-1:0]               fx_q, fy_q;
	logic                        skip_q;
	logic [1:0]                  corner_q;
	logic [WW-1:0]               w_q;
	logic signed [bcd_pkg::ACC_W-1:0] amt_q;
	logic [AW-1:0]               addr_q;
	logic [bcd_pkg::ACC_W-1:0]   rdata_q, sum_q;
	logic [AW:0]                 clr_q;
	logic                        rd_ok_q;

	logic signed [33:0] dx, dy;

	always_comb begin
		dx = 34'(px_q) - 34'(origin_x);
		dy = 34'(py_q) - 34'(origin_y);
	end

	logic [bcd_pkg::CNT_W-1:0] cols_c, rows_c;
	always_comb begin
		cols_c = cols_in_use;
		if (cols_c == '0) cols_c = 7'd1;
		if (32'(cols_c) > MAX_COLS) cols_c = bcd_pkg::CNT_W'(MAX_COLS);
		rows_c = rows_in_use;
		if (rows_c == '0) rows_c = 7'd1;
		if (32'(rows_c) > MAX_ROWS) rows_c = bcd_pkg::CNT_W'(MAX_ROWS);
	end

	logic [BW-1:0] bx, by;
	assign bx = prx_q[PW-1:32];
	assign by = pry_q[PW-1:32];

	logic [WW-1:0] gx, gy, fa, fb;
	always_comb begin
		gx = ONE - fx_q;
		gy = ONE - fy_q;
		case (corner_q)
			2'd0: begin fa = gx;   fb = gy;   end
			2'd1: begin fa = gx;   fb = fy_q; end
			2'd2: begin fa = fx_q; fb = gy;   end
			default: begin fa = fx_q; fb = fy_q; end
		endcase
	end

	logic [2*WW-1:0] wprod;
	assign wprod = fa * fb + (2*WW)'(1 << (FB - 1));

	logic signed [WW+bcd_pkg::POS_W:0] aprod;
	assign aprod = $signed({1'b0, w_q}) * charge_scale
		+ $signed((WW+bcd_pkg::POS_W+1)'(1 << (FB - 1)));

	logic [CW-1:0] ccol;
	logic [RW-1:0] crow;
	always_comb begin
		ccol = corner_q[1] ? c1_q : c0_q;
		crow = corner_q[0] ? RW'(r0_q + 1'b1) : r0_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign sts.clear_done = (clr_q == (AW+1)'(DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.clear_step)
			mem[clr_q[AW-1:0]] <= '0;
		else if (cmd.mem_wr)
			mem[addr_q] <= sum_q;
		if (cmd.mem_rd || cmd.cell_rd)
			rdata_q <= mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_operation;
			lane_q <= in_lane_active;
			px_q   <= in_pos_x;
			py_q   <= in_pos_y;
			rcol_q <= in_read_col;
			rrow_q <= in_read_row;
		end
		if (cmd.locate) begin
			prx_q <= PW'(dx * $signed({1'b0, inv_cell_x}));
			pry_q <= PW'(dy * $signed({1'b0, inv_cell_y}));
			rd_ok_q <= (32'(rcol_q) < MAX_COLS) && (32'(rrow_q) <= MAX_ROWS);
			addr_q <= AW'(32'(rrow_q) * MAX_COLS + 32'(rcol_q));
		end
		if (cmd.check) begin
			skip_q <= prx_q[PW-1] || pry_q[PW-1] || (bx >= BW'(cols_c))
				|| (by >= BW'(rows_c));
			c0_q <= CW'(bx);
			c1_q <= ((bx + 1'b1) >= BW'(cols_c)) ? '0 : CW'(bx + 1'b1);
			r0_q <= RW'(by);
			fx_q <= WW'(prx_q[31:32-FB]);
			fy_q <= WW'(pry_q[31:32-FB]);
			corner_q <= '0;
		end
		if (cmd.next_corner)
			corner_q <= corner_q + 1'b1;
		if (cmd.weight) begin
			w_q <= WW'(wprod >> FB);
			addr_q <= AW'(32'(crow) * MAX_COLS + 32'(ccol));
		end
		if (cmd.amount)
			amt_q <= lane_q ? bcd_pkg::ACC_W'(aprod >>> FB) : '0;
		if (cmd.add)
			sum_q <= rdata_q + amt_q;
	end

	assign sts.is_read     = op_q;
	assign sts.skip        = skip_q;
	assign sts.last_corner = (corner_q == 2'd3);

	always_ff @(posedge clk) begin
		if (cmd.cell_latch) begin
			res_cell_value   <= rd_ok_q ? rdata_q : '0;
			res_col_index    <= rcol_q;
			res_row_index    <= rrow_q;
			res_out_of_range <= 1'b0;
		end else if (cmd.check) begin
			res_cell_value <= '0;
		end else if (cmd.weight && corner_q == 2'd0) begin
			res_col_index    <= bcd_pkg::COL_W'(c0_q);
			res_row_index    <= bcd_pkg::ROW_W'(r0_q);
			res_out_of_range <= 1'b0;
		end else if (cmd.amount && skip_q) begin
			res_col_index    <= '0;
			res_row_index    <= '0;
			res_out_of_range <= 1'b1;
		end
	end
endmodule

// ----- rtl/core/bcd_ctrl.sv -----
module bcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bcd_pkg::dp_cmd_t  cmd,
	input  bcd_pkg::dp_sts_t  sts
);
	bcd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			bcd_pkg::ST_CLEAR: begin
				if (sts.clear_done) state_d = bcd_pkg::ST_IDLE;
				else cmd.clear_step = 1'b1;
			end
			bcd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = bcd_pkg::ST_LOCATE;
				end
			end
			bcd_pkg::ST_LOCATE: begin
				cmd.locate = 1'b1;
				state_d = sts.is_read ? bcd_pkg::ST_READ_WAIT : bcd_pkg::ST_CHECK;
			end
			bcd_pkg::ST_READ_WAIT: begin
				cmd.cell_rd = 1'b1;
				state_d = bcd_pkg::ST_READ_DATA;
			end
			bcd_pkg::ST_READ_DATA: begin
				cmd.cell_latch = 1'b1;
				state_d = bcd_pkg::ST_OUT;
			end
			bcd_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				state_d = bcd_pkg::ST_WEIGHT;
			end
			bcd_pkg::ST_WEIGHT: begin
				cmd.weight = 1'b1;
				state_d = bcd_pkg::ST_AMOUNT;
			end
			bcd_pkg::ST_AMOUNT: begin
				cmd.amount = 1'b1;
				state_d = sts.skip ? bcd_pkg::ST_OUT : bcd_pkg::ST_RD;
			end
			bcd_pkg::ST_RD: begin
				cmd.mem_rd = 1'b1;
				state_d = bcd_pkg::ST_ADD;
			end
			bcd_pkg::ST_ADD: begin
				cmd.add = 1'b1;
				state_d = bcd_pkg::ST_WR;
			end
			bcd_pkg::ST_WR: begin
				cmd.mem_wr = 1'b1;
				if (sts.last_corner) begin
					state_d = bcd_pkg::ST_OUT;
				end else begin
					cmd.next_corner = 1'b1;
					state_d = bcd_pkg::ST_WEIGHT;
				end
			end
			bcd_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = bcd_pkg::ST_IDLE;
			end
			default: state_d = bcd_pkg::ST_IDLE;
		endcase
	end
endmodule

// ----- verif/tb_bilinear_charge_deposit_unit.sv -----
`timescale 1ns / 100ps

module tb_bilinear_charge_deposit_unit;

	typedef struct {
		logic [bcd_pkg::ACC_W-1:0] value;
		logic [bcd_pkg::COL_W-1:0] col;
		logic [bcd_pkg::ROW_W-1:0] row;
		logic                      oor;
	} cell_result_t;

	class deposit_scoreboard;
		logic [bcd_pkg::ACC_W-1:0]        grid[(64+1)*64];
		logic signed [bcd_pkg::POS_W-1:0] org_x, org_y, q_scale;
		logic [bcd_pkg::INV_W-1:0]        inv_x, inv_y;
		logic [bcd_pkg::CNT_W-1:0]        n_cols, n_rows;
		cell_result_t                     pending[$];

		function new();
			foreach (grid[i]) grid[i] = '0;
			org_x = 0; org_y = 0; q_scale = 0;
			inv_x = 24'd65536; inv_y = 24'd65536;
			n_cols = 7'd64; n_rows = 7'd64;
		endfunction

		function void set_reg(logic [bcd_pkg::CFG_IDX_W-1:0] idx,
				logic [bcd_pkg::POS_W-1:0] data);
			case (idx)
				bcd_pkg::REG_ORIGIN_X:     org_x = data;
				bcd_pkg::REG_ORIGIN_Y:     org_y = data;
				bcd_pkg::REG_INV_CELL_X:   inv_x = data[bcd_pkg::INV_W-1:0];
				bcd_pkg::REG_INV_CELL_Y:   inv_y = data[bcd_pkg::INV_W-1:0];
				bcd_pkg::REG_CHARGE_SCALE: q_scale = data;
				bcd_pkg::REG_COLS_IN_USE:  n_cols = data[bcd_pkg::CNT_W-1:0];
				bcd_pkg::REG_ROWS_IN_USE:  n_rows = data[bcd_pkg::CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function bit locate(logic signed [bcd_pkg::POS_W-1:0] pos,
				logic signed [bcd_pkg::POS_W-1:0] org,
				logic [bcd_pkg::INV_W-1:0] inv, output longint base, output longint frac);
			longint d, p;
			d = longint'(pos) - longint'(org);
			p = d * longint'({40'd0, inv});
			base = 0; frac = 0;
			if (p < 0) return 0;
			base = p >>> 32;
			frac = (p >>> (32 - bcd_pkg::FRAC_BITS)) & ((64'd1 << bcd_pkg::FRAC_BITS) - 1);
			return 1;
		endfunction

		function void add_charge(longint col, longint row, longint a, longint b);
			longint w, amount, addr;
			w = (a * b + (64'd1 << (bcd_pkg::FRAC_BITS-1))) >>> bcd_pkg::FRAC_BITS;
			amount = (w * longint'(q_scale) + (64'sd1 << (bcd_pkg::FRAC_BITS-1)))
				>>> bcd_pkg::FRAC_BITS;
			addr = row * 64 + col;
			if (addr < (64+1)*64)
				grid[addr] = grid[addr] + amount[bcd_pkg::ACC_W-1:0];
		endfunction

		function void note_item(logic op, logic signed [bcd_pkg::POS_W-1:0] px,
				logic signed [bcd_pkg::POS_W-1:0] py, logic act,
				logic [bcd_pkg::COL_W-1:0] rc, logic [bcd_pkg::ROW_W-1:0] rr);
			cell_result_t r;
			longint cols, rows, c0, r0, fx, fy, c1, one;
			bit okx, oky;
			r = '{default: '0};
			if (op == bcd_pkg::OP_READ) begin
				if (rr <= 64) r.value = grid[rr * 64 + rc];
				r.col = rc;
				r.row = rr;
				pending.push_back(r);
				return;
			end
			cols = (n_cols < 1) ? 1 : (n_cols > 64) ? 64 : n_cols;
			rows = (n_rows < 1) ? 1 : (n_rows > 64) ? 64 : n_rows;
			one = 64'd1 << bcd_pkg::FRAC_BITS;
			okx = locate(px, org_x, inv_x, c0, fx);
			oky = locate(py, org_y, inv_y, r0, fy);
			if (!okx || !oky || c0 >= cols || r0 >= rows) begin
				r.oor = 1'b1;
			end else begin
				r.col = c0[bcd_pkg::COL_W-1:0];
				r.row = r0[bcd_pkg::ROW_W-1:0];
				if (act) begin
					c1 = (c0 + 1 >= cols) ? 0 : c0 + 1;
					add_charge(c0, r0, one - fx, one - fy);
					add_charge(c0, r0 + 1, one - fx, fy);
					add_charge(c1, r0, fx, one - fy);
					add_charge(c1, r0 + 1, fx, fy);
				end
			end
			pending.push_back(r);
		endfunction

		function string check_result(cell_result_t got);
			cell_result_t e;
			if (pending.size() == 0) return "result with nothing outstanding";
			e = pending.pop_front();
			if (got.value !== e.value)
				return $sformatf("cell_value %h, expected %h", got.value, e.value);
			if (got.col !== e.col) return $sformatf("col_index %0d, expected %0d", got.col, e.col);
			if (got.row !== e.row) return $sformatf("row_index %0d, expected %0d", got.row, e.row);
			if (got.oor !== e.oor) return $sformatf("out_of_range %b, expected %b", got.oor, e.oor);
			return "";
		endfunction
	endclass

	logic                             clk, arst_n;
	logic                             in_valid, in_ready, out_valid, out_ready;
	logic                             operation, lane_active;
	logic signed [bcd_pkg::POS_W-1:0] pos_x, pos_y;
	logic [bcd_pkg::COL_W-1:0]        read_col, col_index;
	logic [bcd_pkg::ROW_W-1:0]        read_row, row_index;
	logic signed [bcd_pkg::ACC_W-1:0] cell_value;
	logic                             out_of_range;
	logic                             cfg_we;
	logic [bcd_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [bcd_pkg::POS_W-1:0]        cfg_data;

	deposit_scoreboard sb = new();
	int errors = 0;
	int send_idle = 0, recv_idle = 0;
	int n_results = 0, n_deposits = 0, n_reads = 0;

	bilinear_charge_deposit_unit uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

	task automatic report(string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		cell_result_t got;
		string msg;
		if (arst_n && out_valid && out_ready) begin
			got.value = cell_value;
			got.col = col_index;
			got.row = row_index;
			got.oor = out_of_range;
			msg = sb.check_result(got);
			n_results++;
			if (msg != "") report(msg);
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic set_config(logic signed [31:0] ox, logic signed [31:0] oy,
			logic [23:0] ix, logic [23:0] iy, logic signed [31:0] qs,
			logic [6:0] nc, logic [6:0] nr);
		logic [31:0] vals[7];
		vals = '{ox, oy, {8'd0, ix}, {8'd0, iy}, qs, {25'd0, nc}, {25'd0, nr}};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= bcd_pkg::CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(bcd_pkg::CFG_IDX_W'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send(logic op, logic signed [31:0] px, logic signed [31:0] py,
			logic act, logic [5:0] rc, logic [6:0] rr);
		int gap;
		if ($urandom_range(99) < send_idle) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pos_x <= px;
		pos_y <= py;
		lane_active <= act;
		read_col <= rc;
		read_row <= rr;
		do @(posedge clk); while (!in_ready);
		sb.note_item(op, px, py, act, rc, rr);
		if (op == bcd_pkg::OP_READ) n_reads++; else n_deposits++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [31:0] pos_in_grid(logic [31:0] org, logic [23:0] inv, int n);
		longint t, d;
		if (inv == 0 || $urandom_range(99) < 15) return $urandom;
		t = longint'($urandom_range(0, n * 65536 + 65535)) - 4096;
		d = (t <<< 16) / longint'({40'd0, inv});
		return org + d[31:0];
	endfunction

	task automatic random_items(int count);
		logic [6:0] rr;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 30) begin
				rr = ($urandom_range(99) < 8) ? 7'($urandom_range(65, 127))
					: 7'($urandom_range(0, 64));
				send(bcd_pkg::OP_READ, $urandom, $urandom, 1'($urandom), 6'($urandom), rr);
			end else begin
				send(bcd_pkg::OP_DEPOSIT, pos_in_grid(sb.org_x, sb.inv_x, sb.n_cols),
					pos_in_grid(sb.org_y, sb.inv_y, sb.n_rows),
					$urandom_range(99) < 85, 6'($urandom), 7'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		operation <= bcd_pkg::OP_DEPOSIT;
		pos_x <= '0;
		pos_y <= '0;
		lane_active <= 1'b0;
		read_col <= '0;
		read_row <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		out_ready <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);

		set_config(0, 0, 24'd65536, 24'd65536, 32'sd65536, 7'd64, 7'd64);
		send(bcd_pkg::OP_DEPOSIT, 32'h0000_0000, 32'h0000_0000, 1'b1, 0, 0);
		send(bcd_pkg::OP_DEPOSIT, 32'h0000_8000, 32'h0000_4000, 1'b1, 0, 0);
		send(bcd_pkg::OP_DEPOSIT, 32'h003F_C000, 32'h0001_2000, 1'b1, 0, 0);
		send(bcd_pkg::OP_DEPOSIT, 32'h0005_1234, 32'h003F_FFFF, 1'b1, 0, 0);
		send(bcd_pkg::OP_DEPOSIT, 32'hFFFF_FFFF, 32'h0000_1000, 1'b1, 0, 0);
		send(bcd_pkg::OP_DEPOSIT, 32'h0040_0000, 32'h0000_1000, 1'b1, 0, 0);
		send(bcd_pkg::OP_DEPOSIT, 32'h0001_0000, 32'h0040_0000, 1'b1, 0, 0);
		send(bcd_pkg::OP_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 0, 0);
		send(bcd_pkg::OP_DEPOSIT, 32'h0002_8000, 32'h0002_8000, 1'b0, 0, 0);
		send(bcd_pkg::OP_READ, 0, 0, 1'b1, 6'd0, 7'd0);
		send(bcd_pkg::OP_READ, 0, 0, 1'b1, 6'd0, 7'd1);
		send(bcd_pkg::OP_READ, 0, 0, 1'b1, 6'd63, 7'd64);
		send(bcd_pkg::OP_READ, 0, 0, 1'b0, 6'd0, 7'd64);
		send(bcd_pkg::OP_READ, 0, 0, 1'b1, 6'd5, 7'd127);
		send(bcd_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 6'd2, 7'd2);
		drain();
		set_config(32'sh8000_0000, 32'sh7FFF_FFFF, 24'd0, 24'hFF_FFFF, 32'sh8000_0000,
			7'd0, 7'd127);
		send(bcd_pkg::OP_DEPOSIT, 32'h1234_5678, 32'h7FFF_FFFF, 1'b1, 0, 0);
		send(bcd_pkg::OP_DEPOSIT, 32'h8000_0000, 32'h7FFF_0000, 1'b1, 0, 0);
		send(bcd_pkg::OP_READ, 0, 0, 1'b1, 6'd0, 7'd0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin send_idle = 29; recv_idle = 85; end
				1: begin send_idle = 85; recv_idle = 29; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			case (ph)
				0: set_config(0, 0, 24'd65536, 24'd65536, 32'sd65536, 7'd64, 7'd64);
				1: set_config(32'sh0003_0000, -32'sh0002_0000, 24'd32768, 24'd131072,
					32'sh7FFF_FFFF, 7'd1, 7'd1);
				2: set_config($urandom, $urandom, 24'($urandom_range(1, 600000)),
					24'($urandom_range(1, 600000)), $urandom, 7'd127, 7'd0);
				3: set_config(-32'sh0010_0000, 32'sh0000_8000, 24'hFF_FFFF, 24'd16384,
					-32'sh0001_8000, 7'd7, 7'd5);
				4: set_config(0, 0, 24'd65536, 24'd65536, 32'sh8000_0000, 7'd2, 7'd64);
				default: set_config($urandom, $urandom, 24'($urandom_range(20000, 300000)),
					24'($urandom_range(20000, 300000)), $urandom,
					7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
			endcase
			random_items(305);
			drain();
		end

		$display("covered %0d deposits and %0d reads, %0d results checked",
			n_deposits, n_reads, n_results);
		$display("eight register settings incl. extremes, three handshake idling patterns");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
